[hdl/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Clocked check, active during reset as well.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

[hdl/srs_pkg.sv]
// ----------------------------------------------------------------------------
// srs_pkg
// Types, constants and helpers of the selective-repeat send table.
// ----------------------------------------------------------------------------
`default_nettype none

package srs_pkg;

  localparam int WINDOW  = 64;
  localparam int MAX_LEN = 2048;

  localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int STEP_W  = $clog2(WINDOW + 1);
  localparam int CNT_W   = 7;
  localparam logic [11:0] LEN_CAP = (MAX_LEN > 4095) ? 12'hFFF : 12'(MAX_LEN);

  localparam int DIV_SH  = 16 + IDX_W;
  localparam int DIV_M   = ((1 << DIV_SH) + WINDOW - 1) / WINDOW;
  localparam int PROD_W  = DIV_SH + 17;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_RETIME  = 3'd1,
    OP_ACK     = 3'd2,
    OP_LOOKUP  = 3'd3,
    OP_ADVANCE = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_CLASH  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_ADV
  } state_e;

  typedef struct packed {
    logic [15:0] seq;
    logic [11:0] len;
    logic [31:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Sequence number modulo WINDOW by reciprocal multiplication.
  function automatic logic [IDX_W-1:0] slot_of(input logic [15:0] s);
    logic [PROD_W-1:0] prod;
    logic [15:0]       quo;
    logic [15:0]       rem;
    prod = PROD_W'(s) * PROD_W'(DIV_M);
    quo  = prod[DIV_SH +: 16];
    rem  = s - 16'(quo * 16'(WINDOW));
    return rem[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hdl/srs_ram.sv]
// ----------------------------------------------------------------------------
// srs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/selective_repeat_send_table.sv]
// ----------------------------------------------------------------------------
// selective_repeat_send_table
// Send-side table of outstanding packets for a selective-repeat sender.
// ----------------------------------------------------------------------------
// Accepts one item when start is high and busy is low. Insert, retime, ack,
// look up and unused opcodes first do the synchronous RAM read of the slot,
// then modify it and write it back; the result strobe done_o is high in the
// cycle after that, and a new item may be accepted in that same cycle.
// Advance frees acked slots at the left window edge, at most WINDOW of them:
// the walk reads one slot per cycle through the single RAM read port. Results
// cannot be held off; done_o is high for one cycle only.
// Valid and acked marks live in flip-flops cleared by reset, so the block
// is ready right after reset.
`default_nettype none

module selective_repeat_send_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode_i,
  input  logic [15:0] seq_i,
  input  logic [11:0] length_i,
  input  logic [31:0] time_now_i,
  input  logic [15:0] limit_seq_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [11:0] hit_length_o,
  output logic [31:0] hit_time_o,
  output logic        hit_acked_o,
  output logic [15:0] window_left_out_o,
  output logic [6:0]  count_stored_o,
  output logic [6:0]  count_acked_o,
  output logic [6:0]  count_unacked_o
);

  import srs_pkg::*;

  state_e             state_q, state_d;
  logic [WINDOW-1:0]  valid_q, valid_d;
  logic [WINDOW-1:0]  acked_q, acked_d;
  logic [15:0]        wl_q, wl_d;
  logic [IDX_W-1:0]   wl_slot_q, wl_slot_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [CNT_W-1:0]   stored_q, stored_d;
  logic [CNT_W-1:0]   ackcnt_q, ackcnt_d;
  logic               done_q, done_d;

  logic [2:0]         op_q;
  logic [15:0]        seq_q;
  logic [11:0]        len_q;
  logic [31:0]        time_q;
  logic [15:0]        limit_q;

  status_e            status_q, status_d;
  logic [11:0]        hit_len_q, hit_len_d;
  logic [31:0]        hit_time_q, hit_time_d;
  logic               hit_ack_q, hit_ack_d;

  logic               ram_re, ram_we;
  logic [IDX_W-1:0]   ram_raddr;
  entry_t             ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0] ram_rbits;

  logic               accept;
  logic               cur_valid, cur_acked, seq_hit, edge_hit;
  logic [15:0]        gap;

  assign accept    = start && (state_q == S_IDLE);
  assign ram_rdata = entry_t'(ram_rbits);
  assign cur_valid = valid_q[rd_idx_q];
  assign cur_acked = acked_q[rd_idx_q];
  assign seq_hit   = (ram_rdata.seq == seq_q);
  assign edge_hit  = (ram_rdata.seq == wl_q);
  assign gap       = limit_q - wl_q;

  srs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (WINDOW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (rd_idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rbits)
  );

  always_comb begin
    state_d    = state_q;
    valid_d    = valid_q;
    acked_d    = acked_q;
    wl_d       = wl_q;
    wl_slot_d  = wl_slot_q;
    rd_idx_d   = rd_idx_q;
    step_d     = step_q;
    stored_d   = stored_q;
    ackcnt_d   = ackcnt_q;
    done_d     = 1'b0;
    status_d   = ST_OK;
    hit_len_d  = '0;
    hit_time_d = '0;
    hit_ack_d  = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = slot_of(seq_i);
    ram_wdata  = ram_rdata;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          ram_re = 1'b1;
          step_d = '0;
          if (opcode_i == OP_ADVANCE) begin
            ram_raddr = wl_slot_q;
            state_d   = S_ADV;
          end else begin
            state_d   = S_EXEC;
          end
          rd_idx_d = ram_raddr;
        end
      end
      S_EXEC: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        unique case (op_q)
          OP_INSERT: begin
            if (cur_valid && !seq_hit) begin
              status_d = ST_CLASH;
            end else begin
              ram_we          = 1'b1;
              ram_wdata.seq   = seq_q;
              ram_wdata.len   = (len_q > LEN_CAP) ? LEN_CAP : len_q;
              ram_wdata.stamp = time_q;
              valid_d[rd_idx_q] = 1'b1;
              acked_d[rd_idx_q] = 1'b0;
              if (!cur_valid) begin
                stored_d = stored_q + CNT_W'(1);
              end else if (cur_acked) begin
                ackcnt_d = ackcnt_q - CNT_W'(1);
              end
            end
          end
          OP_RETIME: begin
            if (cur_valid && seq_hit) begin
              ram_we          = 1'b1;
              ram_wdata.stamp = time_q;
            end else begin
              status_d = ST_ABSENT;
            end
          end
          OP_ACK: begin
            if (cur_valid && seq_hit) begin
              if (!cur_acked) begin
                acked_d[rd_idx_q] = 1'b1;
                ackcnt_d = ackcnt_q + CNT_W'(1);
              end
            end else begin
              status_d = ST_ABSENT;
            end
          end
          OP_LOOKUP: begin
            if (cur_valid && seq_hit) begin
              hit_len_d  = ram_rdata.len;
              hit_time_d = ram_rdata.stamp;
              hit_ack_d  = cur_acked;
            end else begin
              status_d = ST_ABSENT;
            end
          end
          default: ;
        endcase
      end
      S_ADV: begin
        if ((step_q != STEP_W'(WINDOW)) && !gap[15] && cur_valid && edge_hit &&
            cur_acked) begin
          valid_d[rd_idx_q] = 1'b0;
          acked_d[rd_idx_q] = 1'b0;
          stored_d  = stored_q - CNT_W'(1);
          ackcnt_d  = ackcnt_q - CNT_W'(1);
          wl_d      = wl_q + 16'd1;
          wl_slot_d = ((wl_q == 16'hFFFF) || (wl_slot_q == IDX_W'(WINDOW - 1))) ?
                      '0 : wl_slot_q + IDX_W'(1);
          step_d    = step_q + STEP_W'(1);
          ram_re    = 1'b1;
          ram_raddr = wl_slot_d;
          rd_idx_d  = wl_slot_d;
        end else begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      valid_q   <= '0;
      acked_q   <= '0;
      wl_q      <= '0;
      wl_slot_q <= '0;
      rd_idx_q  <= '0;
      step_q    <= '0;
      stored_q  <= '0;
      ackcnt_q  <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      acked_q   <= acked_d;
      wl_q      <= wl_d;
      wl_slot_q <= wl_slot_d;
      rd_idx_q  <= rd_idx_d;
      step_q    <= step_d;
      stored_q  <= stored_d;
      ackcnt_q  <= ackcnt_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= opcode_i;
      seq_q   <= seq_i;
      len_q   <= length_i;
      time_q  <= time_now_i;
      limit_q <= limit_seq_i;
    end
    if (done_d) begin
      status_q   <= status_d;
      hit_len_q  <= hit_len_d;
      hit_time_q <= hit_time_d;
      hit_ack_q  <= hit_ack_d;
    end
  end

  assign busy              = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign status_o          = status_q;
  assign hit_length_o      = hit_len_q;
  assign hit_time_o        = hit_time_q;
  assign hit_acked_o       = hit_ack_q;
  assign window_left_out_o = wl_q;
  assign count_stored_o    = stored_q;
  assign count_acked_o     = ackcnt_q;
  assign count_unacked_o   = stored_q - ackcnt_q;

endmodule

`default_nettype wire

[hdl/selective_repeat_send_table_chk.sv]
// ----------------------------------------------------------------------------
// selective_repeat_send_table_chk
// Port-level checks of the send table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module selective_repeat_send_table_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [11:0] hit_length_o,
  input logic [31:0] hit_time_o,
  input logic        hit_acked_o,
  input logic [15:0] window_left_out_o
);

  import srs_pkg::*;

  logic hit_any;

  assign hit_any = hit_acked_o || (hit_length_o != '0) || (hit_time_o != '0);

  `ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> (!done_o && !busy))
  `ASSERT_CLK(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  `ASSERT_CLK(a_done_after_work, clk_i, rst_ni, done_o |-> (!busy && $past(busy)))
  `ASSERT_CLK(a_edge_moves_in_work, clk_i, rst_ni, !$stable(window_left_out_o) |-> busy)
  `ASSERT_CLK(a_hit_needs_ok, clk_i, rst_ni, (done_o && hit_any) |-> (status_o == ST_OK))

endmodule

bind selective_repeat_send_table selective_repeat_send_table_chk u_chk (.*);

`default_nettype wire
